// File: design/bscr_pkg.sv
// ----------------------------------------------------------------------------
// bscr_pkg: board system-control register block types and constants
// Shared payload types, configuration layout, operation codes and the
// register offset map, imported by every module of the block.
// ----------------------------------------------------------------------------
package bscr_pkg;

    localparam int ADDR_WIDTH  = 12;
    localparam int OFFSET_BITS = 12;
    localparam int DATA_WIDTH  = 32;
    localparam int PADDR_WIDTH = 4;

    localparam logic [ADDR_WIDTH-1:0] ADDR_MASK =
        (OFFSET_BITS >= ADDR_WIDTH) ? {ADDR_WIDTH{1'b1}}
                                    : ADDR_WIDTH'((1 << OFFSET_BITS) - 1);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_BOARD_ID     = 2'd0,
        CFG_PROC_ID_ZERO = 2'd1,
        CFG_DIVIDE_LIMIT = 2'd2,
        CFG_FAST_STEP    = 2'd3
    } cfg_index_t;

    localparam logic [ADDR_WIDTH-1:0] OFF_BOARD_ID  = 12'h000;
    localparam logic [ADDR_WIDTH-1:0] OFF_LED       = 12'h008;
    localparam logic [ADDR_WIDTH-1:0] OFF_OSC0      = 12'h00c;
    localparam logic [ADDR_WIDTH-1:0] OFF_OSC1      = 12'h010;
    localparam logic [ADDR_WIDTH-1:0] OFF_OSC2      = 12'h014;
    localparam logic [ADDR_WIDTH-1:0] OFF_OSC3      = 12'h018;
    localparam logic [ADDR_WIDTH-1:0] OFF_OSC4      = 12'h01c;
    localparam logic [ADDR_WIDTH-1:0] OFF_LOCK      = 12'h020;
    localparam logic [ADDR_WIDTH-1:0] OFF_SLOW_CNT  = 12'h024;
    localparam logic [ADDR_WIDTH-1:0] OFF_FLAG      = 12'h030;
    localparam logic [ADDR_WIDTH-1:0] OFF_FLASH     = 12'h04c;
    localparam logic [ADDR_WIDTH-1:0] OFF_DISPLAY   = 12'h050;
    localparam logic [ADDR_WIDTH-1:0] OFF_FAST_CNT  = 12'h05c;
    localparam logic [ADDR_WIDTH-1:0] OFF_MISC      = 12'h070;
    localparam logic [ADDR_WIDTH-1:0] OFF_PROC_CFG  = 12'h080;
    localparam logic [ADDR_WIDTH-1:0] OFF_PROC_ID0  = 12'h084;
    localparam logic [ADDR_WIDTH-1:0] OFF_PROC_ID1  = 12'h088;
    localparam logic [ADDR_WIDTH-1:0] OFF_INT_MODE  = 12'h0d8;

    localparam logic [DATA_WIDTH-1:0] DISPLAY_VALUE     = 32'h0000_1000;
    localparam logic [DATA_WIDTH-1:0] PROC_ID_ONE_VALUE = 32'hFF00_0000;

    localparam logic [15:0] DIVIDE_LIMIT_RESET = 16'd40000;
    localparam logic [7:0]  FAST_STEP_RESET    = 8'd6;

    typedef struct packed {
        logic [1:0]            op;
        logic [ADDR_WIDTH-1:0] addr;
        logic [DATA_WIDTH-1:0] wdata;
    } cmd_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] rdata;
        logic                  ok;
    } rsp_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] board_id;
        logic [DATA_WIDTH-1:0] processor_id_zero;
        logic [15:0]           divide_limit;
        logic [7:0]            fast_step;
    } cfg_t;

endpackage

// File: design/bscr_cfg_regs.sv
// ----------------------------------------------------------------------------
// bscr_cfg_regs: configuration register file
// APB-style write and read access to the board ID, processor ID, prescaler
// limit and fast counter step.
// ----------------------------------------------------------------------------
module bscr_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bscr_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [bscr_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [bscr_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                             pready,
    output bscr_pkg::cfg_t                   cfg
);
    import bscr_pkg::*;

    cfg_t       cfg_reg;
    cfg_index_t idx;
    logic       wr_en;

    assign idx    = cfg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.board_id          <= '0;
            cfg_reg.processor_id_zero <= '0;
            cfg_reg.divide_limit      <= DIVIDE_LIMIT_RESET;
            cfg_reg.fast_step         <= FAST_STEP_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                CFG_BOARD_ID:     cfg_reg.board_id          <= pwdata;
                CFG_PROC_ID_ZERO: cfg_reg.processor_id_zero <= pwdata;
                CFG_DIVIDE_LIMIT: cfg_reg.divide_limit      <= pwdata[15:0];
                CFG_FAST_STEP:    cfg_reg.fast_step         <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            CFG_BOARD_ID:     prdata = cfg_reg.board_id;
            CFG_PROC_ID_ZERO: prdata = cfg_reg.processor_id_zero;
            CFG_DIVIDE_LIMIT: prdata = {16'd0, cfg_reg.divide_limit};
            CFG_FAST_STEP:    prdata = {24'd0, cfg_reg.fast_step};
            default:          prdata = '0;
        endcase
    end

endmodule

// File: design/bscr_core.sv
// ----------------------------------------------------------------------------
// bscr_core: register decode and state update
// Decodes one command beat, updates the board registers and counters on
// the accepting edge and presents the response for that beat.
// ----------------------------------------------------------------------------
module bscr_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  bscr_pkg::cmd_t cmd,
    input  bscr_pkg::cfg_t cfg,
    output bscr_pkg::rsp_t rsp
);
    import bscr_pkg::*;

    logic [DATA_WIDTH-1:0] led_reg,      led_next;
    logic [DATA_WIDTH-1:0] lock_reg,     lock_next;
    logic [DATA_WIDTH-1:0] flag_reg,     flag_next;
    logic [DATA_WIDTH-1:0] int_mode_reg, int_mode_next;
    logic [DATA_WIDTH-1:0] slow_cnt_reg, slow_cnt_next;
    logic [DATA_WIDTH-1:0] fast_cnt_reg, fast_cnt_next;
    logic [15:0]           prescale_reg, prescale_next;
    logic [ADDR_WIDTH-1:0] off;

    assign off = cmd.addr & ADDR_MASK;

    always_comb
    begin
        led_next      = led_reg;
        lock_next     = lock_reg;
        flag_next     = flag_reg;
        int_mode_next = int_mode_reg;
        slow_cnt_next = slow_cnt_reg;
        fast_cnt_next = fast_cnt_reg;
        prescale_next = prescale_reg;
        rsp.rdata     = '0;
        rsp.ok        = 1'b0;
        case (cmd.op)
            OP_READ:
            begin
                rsp.ok = 1'b1;
                case (off) inside
                    OFF_BOARD_ID: rsp.rdata = cfg.board_id;
                    OFF_LED:      rsp.rdata = led_reg;
                    OFF_OSC0, OFF_OSC1, OFF_OSC2, OFF_OSC3, OFF_OSC4,
                    OFF_FLASH, OFF_MISC, OFF_PROC_CFG:
                                  rsp.rdata = '0;
                    OFF_LOCK:     rsp.rdata = lock_reg;
                    OFF_SLOW_CNT: rsp.rdata = slow_cnt_reg;
                    OFF_FLAG:     rsp.rdata = flag_reg;
                    OFF_DISPLAY:  rsp.rdata = DISPLAY_VALUE;
                    OFF_FAST_CNT: rsp.rdata = fast_cnt_reg;
                    OFF_PROC_ID0: rsp.rdata = cfg.processor_id_zero;
                    OFF_PROC_ID1: rsp.rdata = PROC_ID_ONE_VALUE;
                    OFF_INT_MODE: rsp.rdata = int_mode_reg;
                    default:      rsp.ok    = 1'b0;
                endcase
            end
            OP_WRITE:
            begin
                rsp.ok = 1'b1;
                case (off) inside
                    OFF_LED:      led_next      = cmd.wdata;
                    OFF_LOCK:     lock_next     = cmd.wdata;
                    OFF_FLAG:     flag_next     = cmd.wdata;
                    OFF_INT_MODE: int_mode_next = cmd.wdata;
                    OFF_OSC0, OFF_OSC1, OFF_OSC2, OFF_OSC3, OFF_OSC4,
                    OFF_FLASH, OFF_DISPLAY, OFF_MISC:
                                  ;
                    default:      rsp.ok = 1'b0;
                endcase
            end
            OP_TICK:
            begin
                rsp.ok = 1'b1;
                if (prescale_reg >= cfg.divide_limit)
                begin
                    slow_cnt_next = slow_cnt_reg + 32'd1;
                    prescale_next = '0;
                end
                else
                begin
                    prescale_next = prescale_reg + 16'd1;
                end
                fast_cnt_next = fast_cnt_reg + {24'd0, cfg.fast_step};
            end
            default:
            begin
                rsp.ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg      <= '0;
            lock_reg     <= '0;
            flag_reg     <= '0;
            int_mode_reg <= '0;
            slow_cnt_reg <= '0;
            fast_cnt_reg <= '0;
            prescale_reg <= '0;
        end
        else if (fire)
        begin
            led_reg      <= led_next;
            lock_reg     <= lock_next;
            flag_reg     <= flag_next;
            int_mode_reg <= int_mode_next;
            slow_cnt_reg <= slow_cnt_next;
            fast_cnt_reg <= fast_cnt_next;
            prescale_reg <= prescale_next;
        end
    end

endmodule

// File: design/bscr_out_buf.sv
// ----------------------------------------------------------------------------
// bscr_out_buf: response register with skid stage
// Holds the response beat for the consumer and catches one more beat while
// the consumer stalls, so the command side keeps moving.
// ----------------------------------------------------------------------------
module bscr_out_buf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  bscr_pkg::rsp_t in_rsp,
    output logic           full,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bscr_pkg::rsp_t rsp
);
    import bscr_pkg::*;

    logic main_valid_reg;
    logic skid_valid_reg;
    rsp_t main_reg;
    rsp_t skid_reg;
    logic main_free;

    assign main_free = !main_valid_reg || !rsp_stall;
    assign full      = skid_valid_reg;
    assign rsp_valid = main_valid_reg;
    assign rsp       = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : in_rsp;
        end
        else if (in_fire)
        begin
            skid_reg <= in_rsp;
        end
    end

endmodule

// File: design/board_system_control_registers_top.sv
// ----------------------------------------------------------------------------
// board_system_control_registers_top: board system-control register block
// Bus reads, bus writes and clock ticks against the board control registers.
// ----------------------------------------------------------------------------
// Each command beat (read, write or tick) produces exactly one response beat,
// in order. A command is taken in any cycle in which the response skid stage
// is empty, so back-to-back commands run at one per cycle; the response is
// registered, in the skid stage on a stall. The two-entry response buffer
// lets one further command in while a response waits on a stalled consumer.
// Decode and the register or counter update finish in the accepting cycle.
// Configuration registers sit on the APB port at byte offsets 0x0, 0x4, 0x8
// and 0xC and should be written only while no command is in flight.
module board_system_control_registers_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  bscr_pkg::cmd_t                   cmd,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output bscr_pkg::rsp_t                   rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bscr_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [bscr_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [bscr_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                             pready
);
    import bscr_pkg::*;

    cfg_t cfg;
    rsp_t core_rsp;
    logic fire;
    logic buf_full;

    assign cmd_stall = buf_full;
    assign fire      = cmd_valid && !buf_full;

    bscr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bscr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cmd   (cmd),
        .cfg   (cfg),
        .rsp   (core_rsp)
    );

    bscr_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (fire),
        .in_rsp    (core_rsp),
        .full      (buf_full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    a_stall_needs_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> rsp_valid)
        else $error("command stalled with no response pending");

    a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && !rsp_valid) |=> rsp_valid)
        else $error("accepted command produced no response");

    a_tick_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && !rsp_valid && cmd.op == OP_TICK)
        |=> (rsp.ok && rsp.rdata == '0))
        else $error("tick response not ok with zero data");
`endif

endmodule
